### hw/rtl/rmsc_pkg.sv
// ----------------------------------------------------------------------------
// rmsc_pkg: shared constants and types for the rms current block
// Widths, window length, scale factor and the control/status bundles
// that pass between the sequencer and the window datapath.
// ----------------------------------------------------------------------------
package rmsc_pkg;

  // converter sample
  localparam int SAMPLE_W = 10;

  // samples per window; must be a power of two (mean is a plain shift)
  localparam int WINDOW = 1024;
  localparam int CNT_W  = $clog2(WINDOW);

  // d = 2*(sample+offset) - 1023, signed, and its square
  localparam int OFFSET_W = SAMPLE_W + 1;
  localparam int D_W      = SAMPLE_W + 2;
  localparam int SQ_W     = 2 * D_W - 2;
  localparam int SUM_W    = 34;

  localparam logic [D_W:0]        D_BIAS     = (D_W + 1)'(2 ** SAMPLE_W - 1);
  localparam logic [OFFSET_W-1:0] OFFSET_MID = OFFSET_W'(2 ** (SAMPLE_W - 1));

  // mean in Q.16 and its integer root
  localparam int FRAC_W = 16;
  localparam int MEAN_W = SUM_W + FRAC_W - CNT_W;
  localparam int ROOT_W = (MEAN_W + 1) / 2;
  localparam int VAL_W  = 2 * ROOT_W;

  // 2500 / (1023 * 0.185) in Q4.16, rounded
  localparam int                SCALE_W   = 20;
  localparam logic [SCALE_W-1:0] SCALE_Q16 = SCALE_W'(865710);
  localparam int                PROD_W    = ROOT_W + SCALE_W;
  localparam int                RND_SHIFT = 24;

  localparam int CUR_W = 16;

  localparam logic [SAMPLE_W-1:0] THR_RESET = SAMPLE_W'(10);

  typedef struct packed {
    logic load;     // capture the sample
    logic square;   // form d*d
    logic accum;    // add to sum, update min/max and count
    logic clear;    // window end: back to empty window
    logic recal;    // window end with low swing: new offset
  } win_ctrl_t;

  typedef struct packed {
    logic last;       // the beat being accumulated closes the window
    logic low_swing;  // max - min below the drift threshold
  } win_stat_t;

endpackage

### hw/rtl/rmsc_window.sv
// ----------------------------------------------------------------------------
// rmsc_window: per-window datapath
// Holds the offset, the running min/max, the sum of squares and the sample
// count. One sample takes a square step and an accumulate step.
// ----------------------------------------------------------------------------
module rmsc_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rmsc_pkg::SAMPLE_W-1:0] sample,
  input  logic [rmsc_pkg::SAMPLE_W-1:0] drift_threshold,
  input  rmsc_pkg::win_ctrl_t           ctrl,
  output rmsc_pkg::win_stat_t           stat,
  output logic [rmsc_pkg::SUM_W-1:0]    square_sum
);

  logic [rmsc_pkg::SAMPLE_W-1:0]        sample_reg;
  logic signed [rmsc_pkg::OFFSET_W-1:0] offset;
  logic [rmsc_pkg::CNT_W-1:0]           sample_count;
  logic [rmsc_pkg::SAMPLE_W-1:0]        window_max;
  logic [rmsc_pkg::SAMPLE_W-1:0]        window_min;
  logic [rmsc_pkg::SQ_W-1:0]            square;

  logic signed [rmsc_pkg::D_W-1:0]      level;
  logic [rmsc_pkg::D_W:0]               d_wide;
  logic signed [rmsc_pkg::D_W-1:0]      d;
  logic signed [2*rmsc_pkg::D_W-1:0]    d_sq;
  logic [rmsc_pkg::SAMPLE_W:0]          mid_sum;

  assign level = $signed({{(rmsc_pkg::D_W - rmsc_pkg::SAMPLE_W){1'b0}}, sample_reg})
               + $signed({{(rmsc_pkg::D_W - rmsc_pkg::OFFSET_W){offset[rmsc_pkg::OFFSET_W-1]}},
                          offset});
  assign d_wide  = {level, 1'b0} - rmsc_pkg::D_BIAS;
  assign d       = $signed(d_wide[rmsc_pkg::D_W-1:0]);
  assign d_sq    = d * d;
  assign mid_sum = {1'b0, window_max} + {1'b0, window_min};

  assign stat.last      = (sample_count == rmsc_pkg::CNT_W'(rmsc_pkg::WINDOW - 1));
  assign stat.low_swing = (window_max - window_min) < drift_threshold;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sample_reg <= sample;
    end
    if (ctrl.square) begin
      square <= d_sq[rmsc_pkg::SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset       <= '0;
      sample_count <= '0;
      window_max   <= '0;
      window_min   <= '1;
      square_sum   <= '0;
    end else begin
      if (ctrl.accum) begin
        sample_count <= sample_count + 1'b1;
        square_sum   <= square_sum + rmsc_pkg::SUM_W'(square);
        if (sample_reg > window_max) begin
          window_max <= sample_reg;
        end
        if (sample_reg < window_min) begin
          window_min <= sample_reg;
        end
      end
      if (ctrl.recal) begin
        // offset = 512 - floor((max + min) / 2), always in -511..512
        offset <= $signed(rmsc_pkg::OFFSET_MID - {1'b0, mid_sum[rmsc_pkg::SAMPLE_W:1]});
      end
      if (ctrl.clear) begin
        sample_count <= '0;
        window_max   <= '0;
        window_min   <= '1;
        square_sum   <= '0;
      end
    end
  end

endmodule

### hw/rtl/rmsc_isqrt.sv
// ----------------------------------------------------------------------------
// rmsc_isqrt: iterative integer square root
// Bit-pair restoring method, one result bit per cycle.
// ----------------------------------------------------------------------------
module rmsc_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rmsc_pkg::VAL_W-1:0]  radicand,
  output logic                        running,
  output logic                        done,
  output logic [rmsc_pkg::ROOT_W-1:0] root
);

  localparam int STEP_W = $clog2(rmsc_pkg::ROOT_W + 1);

  logic [rmsc_pkg::VAL_W-1:0] rem;
  logic [rmsc_pkg::VAL_W:0]   acc;
  logic [rmsc_pkg::VAL_W-1:0] bit_mask;
  logic [STEP_W-1:0]          step;

  logic [rmsc_pkg::VAL_W:0]   trial;
  logic                       fits;

  assign trial = acc + {1'b0, bit_mask};
  assign fits  = {1'b0, rem} >= trial;
  assign root  = acc[rmsc_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= radicand;
      acc      <= '0;
      bit_mask <= {2'b01, {(rmsc_pkg::VAL_W - 2){1'b0}}};
    end else if (running) begin
      if (fits) begin
        rem <= rem - trial[rmsc_pkg::VAL_W-1:0];
        acc <= (acc >> 1) + {1'b0, bit_mask};
      end else begin
        acc <= acc >> 1;
      end
      bit_mask <= bit_mask >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == STEP_W'(rmsc_pkg::ROOT_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  property p_no_restart;
    @(posedge clk) disable iff (rst) running |-> !start;
  endproperty
  a_no_restart: assert property (p_no_restart)
    else $error("isqrt restarted while running");

  property p_done_after_run;
    @(posedge clk) disable iff (rst) done |-> $past(running) && !running;
  endproperty
  a_done_after_run: assert property (p_done_after_run)
    else $error("isqrt done without a finished run");

  property p_root_fits;
    @(posedge clk) disable iff (rst) done |-> acc[rmsc_pkg::VAL_W:rmsc_pkg::ROOT_W] == '0;
  endproperty
  a_root_fits: assert property (p_root_fits)
    else $error("isqrt root overflows its width");

endmodule

### hw/rtl/rms_current_from_adc_window.sv
// ----------------------------------------------------------------------------
// rms_current_from_adc_window: true rms current over sample windows
// Accumulates squared, offset-corrected samples; at each window end it
// either recalibrates the zero offset or reports the rms current in mA.
// ----------------------------------------------------------------------------
// Ordinary sample: busy through the square and accumulate states, no result.
// Window-closing sample: low swing gives the result after the square,
//   accumulate and evaluate states; otherwise the root, multiply and output
//   states follow, the root state waiting on the one-bit-per-cycle square root unit.
// One sample in flight at a time; results are single-cycle done strobes.
// Synchronous reset: threshold 10, offset 0, empty window, idle.
module rms_current_from_adc_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rmsc_pkg::SAMPLE_W-1:0] sample,
  output logic                          done,
  output logic [rmsc_pkg::CUR_W-1:0]    current_ma,
  output logic                          recalibrated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rmsc_pkg::SAMPLE_W-1:0] cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SQUARE = 7'b0000010,
    S_ACCUM  = 7'b0000100,
    S_EVAL   = 7'b0001000,
    S_ROOT   = 7'b0010000,
    S_MUL    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [rmsc_pkg::SAMPLE_W-1:0] drift_threshold;
  rmsc_pkg::win_ctrl_t           ctrl;
  rmsc_pkg::win_stat_t           stat;
  logic [rmsc_pkg::SUM_W-1:0]    square_sum;

  logic                          root_start;
  logic                          root_running;
  logic                          root_done;
  logic [rmsc_pkg::ROOT_W-1:0]   root;
  logic [rmsc_pkg::VAL_W-1:0]    radicand;

  logic [rmsc_pkg::PROD_W-1:0]   product;
  logic [rmsc_pkg::PROD_W:0]     rounded;
  logic [rmsc_pkg::PROD_W-rmsc_pkg::RND_SHIFT:0] scaled;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drift_threshold <= rmsc_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      drift_threshold <= cfg_data;
    end
  end

  // mean in Q.16 = sum * 2^16 / WINDOW
  assign radicand = rmsc_pkg::VAL_W'({square_sum, {rmsc_pkg::FRAC_W{1'b0}}} >> rmsc_pkg::CNT_W);

  always_comb begin
    state_next = state;
    ctrl       = '0;
    root_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        ctrl.square = 1'b1;
        state_next  = S_ACCUM;
      end
      S_ACCUM: begin
        ctrl.accum = 1'b1;
        state_next = stat.last ? S_EVAL : S_IDLE;
      end
      S_EVAL: begin
        ctrl.clear = 1'b1;
        if (stat.low_swing) begin
          ctrl.recal = 1'b1;
          state_next = S_IDLE;
        end else begin
          root_start = 1'b1;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (root_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  rmsc_window u_window (
    .clk             (clk),
    .rst             (rst),
    .sample          (sample),
    .drift_threshold (drift_threshold),
    .ctrl            (ctrl),
    .stat            (stat),
    .square_sum      (square_sum)
  );

  rmsc_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (radicand),
    .running  (root_running),
    .done     (root_done),
    .root     (root)
  );

  // scale the root, then round half up and saturate
  always_ff @(posedge clk) begin
    if (state == S_ROOT && root_done) begin
      product <= root * rmsc_pkg::SCALE_Q16;
    end
  end

  assign rounded = {1'b0, product} + (rmsc_pkg::PROD_W + 1)'(1 << (rmsc_pkg::RND_SHIFT - 1));
  assign scaled  = rounded[rmsc_pkg::PROD_W:rmsc_pkg::RND_SHIFT];

  always_ff @(posedge clk) begin
    if (state == S_EVAL && stat.low_swing) begin
      current_ma   <= '0;
      recalibrated <= 1'b1;
    end else if (state == S_OUT) begin
      current_ma   <= (scaled > (rmsc_pkg::PROD_W - rmsc_pkg::RND_SHIFT + 1)'({rmsc_pkg::CUR_W{1'b1}}))
                    ? '1 : scaled[rmsc_pkg::CUR_W-1:0];
      recalibrated <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_OUT) || (state == S_EVAL && stat.low_swing);
    end
  end

  property p_single_strobe;
    @(posedge clk) disable iff (rst) done |=> !done;
  endproperty
  a_single_strobe: assert property (p_single_strobe)
    else $error("result strobe held for two cycles");

  property p_recal_zero;
    @(posedge clk) disable iff (rst) done && recalibrated |-> current_ma == '0;
  endproperty
  a_recal_zero: assert property (p_recal_zero)
    else $error("recalibration beat carries a nonzero current");

  property p_root_only_busy;
    @(posedge clk) disable iff (rst) root_running |-> state == S_ROOT;
  endproperty
  a_root_only_busy: assert property (p_root_only_busy)
    else $error("square root running outside its state");

  property p_accept_busy;
    @(posedge clk) disable iff (rst) start && !busy |=> busy;
  endproperty
  a_accept_busy: assert property (p_accept_busy)
    else $error("accepted sample did not raise busy");

endmodule

### test/rms_current_from_adc_window_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rms_current_from_adc_window_check: result predictor and scoreboard
// Watches the sample, config and result channels of the rms current block.
// Each accepted sample updates a local copy of the window state. A closing
// sample queues the expected current or recalibration. Each done strobe is
// compared against the oldest entry in that queue.
// ----------------------------------------------------------------------------
module rms_current_from_adc_window_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [rmsc_pkg::SAMPLE_W-1:0] sample,
  input  logic                          done,
  input  logic [rmsc_pkg::CUR_W-1:0]    current_ma,
  input  logic                          recalibrated,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rmsc_pkg::SAMPLE_W-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import rmsc_pkg::*;

  localparam logic [SAMPLE_W-1:0] DRIFT_AT_RESET = 10'd10;
  localparam longint unsigned     MA_SCALE_Q16   = 64'd865710;
  localparam longint unsigned     MA_ROUND       = 64'd8388608;

  typedef struct packed {
    logic [CUR_W-1:0] current;
    logic             recal;
  } window_result_t;

  window_result_t      window_results_q[$];
  logic [SAMPLE_W-1:0] drift_thr;
  logic signed [10:0]  zero_offset;
  int unsigned         win_samples;
  logic [SAMPLE_W-1:0] win_hi;
  logic [SAMPLE_W-1:0] win_lo;
  logic [33:0]         sq_sum;
  int                  errors = 0;

  assign fail_count = errors;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic clear_window();
    win_samples = 0;
    win_hi      = '0;
    win_lo      = 10'd1023;
    sq_sum      = '0;
  endtask

  task automatic absorb_sample(input logic [SAMPLE_W-1:0] s);
    longint          sv;
    longint          ov;
    longint          d;
    int unsigned     mid;
    longint unsigned mean_q16;
    longint unsigned root_q8;
    longint unsigned ma;
    window_result_t  r;
    if (s > win_hi) win_hi = s;
    if (s < win_lo) win_lo = s;
    sv = s;
    ov = zero_offset;
    d = 2 * (sv + ov) - 1023;
    sq_sum = sq_sum + d * d;
    win_samples++;
    if (win_samples == WINDOW) begin
      if (win_hi - win_lo < drift_thr) begin
        // low swing: re-center instead of measuring
        mid = (int'(win_hi) + int'(win_lo)) / 2;
        zero_offset = 11'(512 - int'(mid));
        r.current = '0;
        r.recal   = 1'b1;
      end else begin
        mean_q16 = (longint'(sq_sum) << 16) / WINDOW;
        root_q8  = int_sqrt(mean_q16);
        ma = (root_q8 * MA_SCALE_Q16 + MA_ROUND) >> 24;
        if (ma > 64'd65535) ma = 64'd65535;
        r.current = ma[CUR_W-1:0];
        r.recal   = 1'b0;
      end
      window_results_q.push_back(r);
      clear_window();
    end
  endtask

  always @(posedge clk) begin
    window_result_t want;
    if (rst) begin
      drift_thr   = DRIFT_AT_RESET;
      zero_offset = '0;
      clear_window();
      window_results_q.delete();
    end else begin
      if (done) begin
        if (window_results_q.size() == 0) begin
          report_mismatch("result with no window closed", current_ma, 0);
        end else begin
          want = window_results_q.pop_front();
          if (current_ma !== want.current)
            report_mismatch("current_ma", current_ma, want.current);
          if (recalibrated !== want.recal)
            report_mismatch("recalibrated", recalibrated, want.recal);
        end
      end
      if (cfg_valid && cfg_ready) drift_thr = cfg_data;
      if (start && !busy) absorb_sample(sample);
    end
    pending <= window_results_q.size();
  end

endmodule

### test/rms_current_from_adc_window_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rms_current_from_adc_window_test: stimulus and verdict for the rms block
// Feeds whole sample windows (flat, banded, extreme and uniform content)
// in random bursts, moves the drift threshold between phases, including
// 0 and 1023, and leaves prediction and checking to the checker module.
// ----------------------------------------------------------------------------
module rms_current_from_adc_window_test;
  import rmsc_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_WINDOWS = 36;

  typedef enum {WIN_UNIFORM, WIN_BAND, WIN_EXTREMES} win_kind_e;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [SAMPLE_W-1:0] sample;
  logic                done;
  logic [CUR_W-1:0]    current_ma;
  logic                recalibrated;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [SAMPLE_W-1:0] cfg_data;
  int                  fail_count;
  int                  pending;
  int                  idle_cycles = 0;
  int                  burst_left  = 0;
  logic [SAMPLE_W-1:0] cur_thr     = 10'd10;

  rms_current_from_adc_window u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .sample      (sample),
    .done        (done),
    .current_ma  (current_ma),
    .recalibrated(recalibrated),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  rms_current_from_adc_window_check u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .sample      (sample),
    .done        (done),
    .current_ma  (current_ma),
    .recalibrated(recalibrated),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // no beat on any channel for too long: hung
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    start  <= 1'b1;
    sample <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(0, 30);
    end
  endtask

  // hold off until every closed window has reported, then let the block settle
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [SAMPLE_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_thr = value;
  endtask

  // band: every sample in [lo, lo+span], both ends hit so the swing is exact
  task automatic send_window(input win_kind_e kind, input int lo, input int span);
    int v;
    for (int i = 0; i < WINDOW; i++) begin
      case (kind)
        WIN_UNIFORM:  v = $urandom_range(0, 1023);
        WIN_EXTREMES: v = (i % 2) ? 1023 : 0;
        default: begin
          if (i == 0) v = lo;
          else if (i == 1) v = lo + span;
          else v = lo + $urandom_range(0, span);
        end
      endcase
      send_sample(v[SAMPLE_W-1:0]);
    end
  endtask

  task automatic send_random_window();
    int span;
    int lo;
    case ($urandom_range(0, 9))
      0, 1, 2: send_window(WIN_UNIFORM, 0, 0);
      3:       send_window(WIN_EXTREMES, 0, 0);
      default: begin
        case ($urandom_range(0, 3))
          0:       span = (cur_thr > 0) ? cur_thr - 1 : 0;
          1:       span = cur_thr;
          2:       span = $urandom_range(0, 40);
          default: span = $urandom_range(0, 1023);
        endcase
        lo = $urandom_range(0, 1023 - span);
        send_window(WIN_BAND, lo, span);
      end
    endcase
  endtask

  initial begin
    logic [SAMPLE_W-1:0] thr;
    rst       = 1'b1;
    start     = 1'b0;
    sample    = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset threshold: offset walks to +512, then -511
    send_window(WIN_BAND, 512, 0);
    send_window(WIN_BAND, 0, 0);
    send_window(WIN_EXTREMES, 0, 0);
    send_window(WIN_BAND, 1023, 0);
    send_window(WIN_UNIFORM, 0, 0);

    // zero threshold: a flat window is measured
    write_threshold(10'd0);
    send_window(WIN_BAND, 300, 0);
    send_window(WIN_UNIFORM, 0, 0);

    write_threshold(10'd1023);
    send_window(WIN_EXTREMES, 0, 0);
    send_window(WIN_UNIFORM, 0, 0);
    send_window(WIN_BAND, 0, 1022);

    // swing just below and at the threshold
    write_threshold(10'd10);
    send_window(WIN_BAND, 200, 9);
    send_window(WIN_BAND, 200, 10);
    send_window(WIN_BAND, 1013, 10);

    for (int w = 0; w < RANDOM_WINDOWS; w++) begin
      if (w % 4 == 0) begin
        case ($urandom_range(0, 5))
          0:       thr = 10'd0;
          1:       thr = 10'd1023;
          2, 3:    thr = $urandom_range(1, 40);
          default: thr = $urandom_range(0, 1023);
        endcase
        write_threshold(thr);
      end else if ($urandom_range(0, 2) == 0) begin
        drain();
      end
      send_random_window();
    end

    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/rmsc_pkg.sv
hw/rtl/rmsc_window.sv
hw/rtl/rmsc_isqrt.sv
hw/rtl/rms_current_from_adc_window.sv
test/rms_current_from_adc_window_check.sv
test/rms_current_from_adc_window_test.sv
